### hdl/met_pkg.sv
// Shared types and constants for the Mandelbrot escape-time core.
`timescale 1ns / 1ps
`default_nettype none
package met_pkg;

   // Fraction bits of the fixed-point format of c and z.
   localparam int FRAC_BITS   = 12;
   localparam int COORD_WIDTH = 16;
   localparam int COUNT_WIDTH = 16;

   // While |z|^2 <= 4 every part of z stays within 2 << FRAC_BITS. One update
   // then adds at most 2^(FRAC_BITS+3) to c, so this width holds every z.
   localparam int Z_WIDTH    = ((FRAC_BITS + 3 > COORD_WIDTH - 1) ?
                                (FRAC_BITS + 3) : (COORD_WIDTH - 1)) + 2;
   localparam int PROD_WIDTH = 2 * Z_WIDTH;
   localparam int NORM_WIDTH = PROD_WIDTH + 1;

   // The value 4 with 2*FRAC_BITS fraction bits.
   localparam logic signed [NORM_WIDTH-1:0] NORM_LIMIT =
      NORM_WIDTH'(1) <<< (2 * FRAC_BITS + 2);

   localparam logic [COUNT_WIDTH-1:0] MAX_ITER_RESET = COUNT_WIDTH'(256);

   localparam int QUEUE_DEPTH       = 2;
   localparam int QUEUE_INDEX_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] c_real;
      logic signed [COORD_WIDTH-1:0] c_imag;
      logic                          zero_limit;
   } met_item_type;

   typedef struct packed {
      logic [QUEUE_COUNT_WIDTH-1:0] count;
      logic                         full;
      logic                         not_empty;
   } met_queue_status_type;

   typedef struct packed {
      logic active;
      logic in_update;
   } met_back_status_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_MUL,
      BACK_UPD
   } met_back_state_type;

endpackage
`default_nettype wire

### hdl/mandelbrot_escape_time_core.sv
// Top level of the Mandelbrot escape-time core.
//
//   channel   ports                                   transfer when
//   -------   -------------------------------------   ----------------------
//   request   start, busy, req_c_real, req_c_imag     start high, busy low
//   result    rsp_strobe, rsp_escape_count            rsp_strobe high
//   config    csr_valid, csr_ready, csr_max_iterations csr_valid and csr_ready
//
// Each iteration has two steps: the products of z, then the norm check and
// the new z; a point under a zero limit skips the products. Busy is high
// while the two-entry queue is full. Reset is synchronous, empties the queue
// and sets the limit to 256. The receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none
module mandelbrot_escape_time_core (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire logic signed [met_pkg::COORD_WIDTH-1:0] req_c_real,
   input  wire logic signed [met_pkg::COORD_WIDTH-1:0] req_c_imag,
   output logic                                        rsp_strobe,
   output logic [met_pkg::COUNT_WIDTH-1:0]             rsp_escape_count,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [met_pkg::COUNT_WIDTH-1:0]        csr_max_iterations
);
   import met_pkg::*;

   met_queue_status_type   queue_status;
   met_back_status_type    back_status;
   met_item_type           push_item;
   met_item_type           head_item;
   logic                   push;
   logic                   pop;
   logic [COUNT_WIDTH-1:0] max_iterations;

   met_front u_front (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .req_c_real         (req_c_real),
      .req_c_imag         (req_c_imag),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_max_iterations (csr_max_iterations),
      .queue_status       (queue_status),
      .busy               (busy),
      .push               (push),
      .push_item          (push_item),
      .max_iterations     (max_iterations)
   );

   met_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (queue_status)
   );

   met_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_item        (head_item),
      .queue_status     (queue_status),
      .max_iterations   (max_iterations),
      .pop              (pop),
      .rsp_strobe       (rsp_strobe),
      .rsp_escape_count (rsp_escape_count),
      .status           (back_status)
   );

   // A result only follows a norm check of the iteration sequencer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(back_status.in_update))
      else $error("result strobe without a preceding norm check");

   // An accepted point leaves the queue non-empty in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (queue_status.count != '0))
      else $error("accepted point lost from the queue");

   // An idle sequencer takes a waiting point at once.
   assert property (@(posedge clock) disable iff (reset)
      (queue_status.not_empty && !back_status.active) |-> pop)
      else $error("waiting point not taken by idle sequencer");

   // An escape count never exceeds the iteration limit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_escape_count <= max_iterations))
      else $error("escape count above the iteration limit");

endmodule
`default_nettype wire

### hdl/met_front.sv
// Front end: takes points in, holds the iteration limit and tags each point.
`timescale 1ns / 1ps
`default_nettype none
module met_front (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   input  wire logic signed [met_pkg::COORD_WIDTH-1:0] req_c_real,
   input  wire logic signed [met_pkg::COORD_WIDTH-1:0] req_c_imag,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [met_pkg::COUNT_WIDTH-1:0]        csr_max_iterations,
   input  wire met_pkg::met_queue_status_type          queue_status,
   output logic                                        busy,
   output logic                                        push,
   output met_pkg::met_item_type                       push_item,
   output logic [met_pkg::COUNT_WIDTH-1:0]             max_iterations
);
   import met_pkg::*;

   logic [COUNT_WIDTH-1:0] max_iter_ff;
   logic [COUNT_WIDTH-1:0] max_iter_in;

   assign csr_ready = 1'b1;
   assign busy      = queue_status.full;
   assign push      = start && !queue_status.full;

   always_comb begin
      max_iter_in = max_iter_ff;
      if (csr_valid && csr_ready) begin
         max_iter_in = csr_max_iterations;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= MAX_ITER_RESET;
      end else begin
         max_iter_ff <= max_iter_in;
      end
   end

   // A point under a zero limit never iterates; the back end skips its multiply.
   always_comb begin
      push_item.c_real     = req_c_real;
      push_item.c_imag     = req_c_imag;
      push_item.zero_limit = (max_iter_ff == '0);
   end

   assign max_iterations = max_iter_ff;

endmodule
`default_nettype wire

### hdl/met_queue.sv
// Short queue of tagged points between the front and the back end.
`timescale 1ns / 1ps
`default_nettype none
module met_queue (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   input  wire met_pkg::met_item_type         push_item,
   input  wire logic                          pop,
   output met_pkg::met_item_type              head_item,
   output met_pkg::met_queue_status_type      status
);
   import met_pkg::*;

   met_item_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_INDEX_WIDTH-1:0] wr_ptr_ff;
   logic [QUEUE_INDEX_WIDTH-1:0] wr_ptr_in;
   logic [QUEUE_INDEX_WIDTH-1:0] rd_ptr_ff;
   logic [QUEUE_INDEX_WIDTH-1:0] rd_ptr_in;
   logic [QUEUE_COUNT_WIDTH-1:0] count_ff;
   logic [QUEUE_COUNT_WIDTH-1:0] count_in;
   logic                         do_push;
   logic                         do_pop;

   assign do_push = push && (count_ff != QUEUE_COUNT_WIDTH'(QUEUE_DEPTH));
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_INDEX_WIDTH'(QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_INDEX_WIDTH'(QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item        = entry_ff[rd_ptr_ff];
   assign status.count     = count_ff;
   assign status.full      = (count_ff == QUEUE_COUNT_WIDTH'(QUEUE_DEPTH));
   assign status.not_empty = (count_ff != '0);

endmodule
`default_nettype wire

### hdl/met_back.sv
// Back end: iterates z = z*z + c for one point and reports its escape count.
`timescale 1ns / 1ps
`default_nettype none
module met_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire met_pkg::met_item_type             head_item,
   input  wire met_pkg::met_queue_status_type     queue_status,
   input  wire logic [met_pkg::COUNT_WIDTH-1:0]   max_iterations,
   output logic                                   pop,
   output logic                                   rsp_strobe,
   output logic [met_pkg::COUNT_WIDTH-1:0]        rsp_escape_count,
   output met_pkg::met_back_status_type           status
);
   import met_pkg::*;

   met_back_state_type state_ff;
   met_back_state_type state_in;

   logic signed [COORD_WIDTH-1:0] cr_ff;
   logic signed [COORD_WIDTH-1:0] ci_ff;
   logic signed [Z_WIDTH-1:0]     zr_ff;
   logic signed [Z_WIDTH-1:0]     zr_in;
   logic signed [Z_WIDTH-1:0]     zi_ff;
   logic signed [Z_WIDTH-1:0]     zi_in;
   logic signed [PROD_WIDTH-1:0]  rr_ff;
   logic signed [PROD_WIDTH-1:0]  rr_in;
   logic signed [PROD_WIDTH-1:0]  ii_ff;
   logic signed [PROD_WIDTH-1:0]  ii_in;
   logic signed [PROD_WIDTH-1:0]  ri_ff;
   logic signed [PROD_WIDTH-1:0]  ri_in;
   logic [COUNT_WIDTH-1:0]        iter_ff;
   logic [COUNT_WIDTH-1:0]        iter_in;
   logic                          strobe_ff;
   logic                          strobe_in;
   logic [COUNT_WIDTH-1:0]        count_out_ff;
   logic [COUNT_WIDTH-1:0]        count_out_in;

   logic signed [NORM_WIDTH-1:0]  norm;
   logic signed [NORM_WIDTH-1:0]  re_diff;
   logic signed [NORM_WIDTH-1:0]  re_sum;
   logic signed [NORM_WIDTH-1:0]  im_sum;
   logic                          escaped;
   logic                          at_limit;
   logic                          finish;
   logic                          advance;
   logic                          load;

   // The products in hand belong to z after iter_ff iterations, so their sum
   // is the norm to check for that iteration.
   assign norm     = {rr_ff[PROD_WIDTH-1], rr_ff} + {ii_ff[PROD_WIDTH-1], ii_ff};
   assign escaped  = (iter_ff != '0) && (norm > NORM_LIMIT);
   assign at_limit = (iter_ff == max_iterations);

   // Arithmetic right shifts give the floor; 2*ri/2^F is ri shifted by F-1.
   assign re_diff = {rr_ff[PROD_WIDTH-1], rr_ff} - {ii_ff[PROD_WIDTH-1], ii_ff};
   assign re_sum  = (re_diff >>> FRAC_BITS)
                  + $signed({{(NORM_WIDTH-COORD_WIDTH){cr_ff[COORD_WIDTH-1]}}, cr_ff});
   assign im_sum  = ($signed({ri_ff[PROD_WIDTH-1], ri_ff}) >>> (FRAC_BITS - 1))
                  + $signed({{(NORM_WIDTH-COORD_WIDTH){ci_ff[COORD_WIDTH-1]}}, ci_ff});

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (queue_status.not_empty) begin
               state_in = head_item.zero_limit ? BACK_UPD : BACK_MUL;
            end
         end
         BACK_MUL: begin
            state_in = BACK_UPD;
         end
         BACK_UPD: begin
            state_in = (escaped || at_limit) ? BACK_IDLE : BACK_MUL;
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_comb begin
      load    = 1'b0;
      finish  = 1'b0;
      advance = 1'b0;
      unique case (state_ff)
         BACK_IDLE: begin
            load = queue_status.not_empty;
         end
         BACK_MUL: begin
            load = 1'b0;
         end
         BACK_UPD: begin
            finish  = escaped || at_limit;
            advance = !(escaped || at_limit);
         end
         default: begin
            load = 1'b0;
         end
      endcase
   end

   always_comb begin
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      iter_in      = iter_ff;
      rr_in        = PROD_WIDTH'(zr_ff) * PROD_WIDTH'(zr_ff);
      ii_in        = PROD_WIDTH'(zi_ff) * PROD_WIDTH'(zi_ff);
      ri_in        = PROD_WIDTH'(zr_ff) * PROD_WIDTH'(zi_ff);
      strobe_in    = finish;
      count_out_in = count_out_ff;
      if (load) begin
         zr_in   = '0;
         zi_in   = '0;
         iter_in = '0;
      end else if (advance) begin
         zr_in   = re_sum[Z_WIDTH-1:0];
         zi_in   = im_sum[Z_WIDTH-1:0];
         iter_in = iter_ff + 1'b1;
      end
      if (finish) begin
         count_out_in = escaped ? iter_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BACK_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cr_ff <= head_item.c_real;
         ci_ff <= head_item.c_imag;
      end
      zr_ff        <= zr_in;
      zi_ff        <= zi_in;
      iter_ff      <= iter_in;
      count_out_ff <= count_out_in;
      if (state_ff == BACK_MUL) begin
         rr_ff <= rr_in;
         ii_ff <= ii_in;
         ri_ff <= ri_in;
      end
   end

   assign pop              = load;
   assign rsp_strobe       = strobe_ff;
   assign rsp_escape_count = count_out_ff;
   assign status.active    = (state_ff != BACK_IDLE);
   assign status.in_update = (state_ff == BACK_UPD);

endmodule
`default_nettype wire

### tb/escape_time_checker.sv
// Checker that predicts the escape count of every accepted point and compares the core's results.
`timescale 1ns / 1ps
module escape_time_checker (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   input  wire logic                                   busy,
   input  wire logic signed [met_pkg::COORD_WIDTH-1:0] req_c_real,
   input  wire logic signed [met_pkg::COORD_WIDTH-1:0] req_c_imag,
   input  wire logic                                   rsp_strobe,
   input  wire logic [met_pkg::COUNT_WIDTH-1:0]        rsp_escape_count,
   input  wire logic                                   csr_valid,
   input  wire logic                                   csr_ready,
   input  wire logic [met_pkg::COUNT_WIDTH-1:0]        csr_max_iterations,
   output int                                          errors,
   output int                                          pending
);
   import met_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic signed [COORD_WIDTH-1:0] c_real;
      logic signed [COORD_WIDTH-1:0] c_imag;
      logic [COUNT_WIDTH-1:0]        limit;
      logic [COUNT_WIDTH-1:0]        count;
   } point_outcome_type;

   logic [COUNT_WIDTH-1:0] iter_limit = MAX_ITER_RESET;
   point_outcome_type      expected_outcomes[$];
   point_outcome_type      oldest;
   point_outcome_type      fresh;
   int                     mismatches = 0;

   // Iterates z = z*z + c from zero and returns the first iteration whose
   // norm is strictly above four, or zero when none is within the limit.
   function automatic logic [COUNT_WIDTH-1:0] escape_iteration(
      input logic signed [COORD_WIDTH-1:0] c_re,
      input logic signed [COORD_WIDTH-1:0] c_im,
      input logic [COUNT_WIDTH-1:0]        limit
   );
      longint z_re;
      longint z_im;
      longint next_re;
      longint next_im;
      longint bound;
      bound = longint'(4) <<< (2 * FRAC_BITS);
      z_re  = 0;
      z_im  = 0;
      for (int n = 1; n <= int'(limit); n++) begin
         // An arithmetic shift of a signed value rounds toward minus infinity.
         next_re = ((z_re * z_re - z_im * z_im) >>> FRAC_BITS) + longint'(c_re);
         next_im = ((2 * z_re * z_im) >>> FRAC_BITS) + longint'(c_im);
         z_re    = next_re;
         z_im    = next_im;
         if (z_re * z_re + z_im * z_im > bound) begin
            return COUNT_WIDTH'(n);
         end
      end
      return '0;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_outcomes.delete();
         iter_limit = MAX_ITER_RESET;
      end else begin
         if (rsp_strobe) begin
            if (expected_outcomes.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("%0t: result with no point waiting: escape_count %0d",
                           $realtime, rsp_escape_count);
               end
            end else begin
               oldest = expected_outcomes.pop_front();
               if (rsp_escape_count !== oldest.count) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("%0t: c = (%0d, %0d), limit %0d: escape_count %0d, expected %0d",
                              $realtime, oldest.c_real, oldest.c_imag, oldest.limit,
                              rsp_escape_count, oldest.count);
                  end
               end
            end
         end
         if (start && !busy) begin
            fresh.c_real = req_c_real;
            fresh.c_imag = req_c_imag;
            fresh.limit  = iter_limit;
            fresh.count  = escape_iteration(req_c_real, req_c_imag, iter_limit);
            expected_outcomes.insert(expected_outcomes.size(), fresh);
         end
         if (csr_valid && csr_ready) begin
            iter_limit = csr_max_iterations;
         end
      end
      errors  <= mismatches;
      pending <= expected_outcomes.size();
   end

endmodule

### tb/tb.sv
// Top of the testbench: stimulus, configuration phases, watchdog and verdict for the core.
`timescale 1ns / 1ps
module tb;
   import met_pkg::*;

   localparam int WATCHDOG_LIMIT = 600000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_POINTS   = 190;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic signed [COORD_WIDTH-1:0] req_c_real = '0;
   logic signed [COORD_WIDTH-1:0] req_c_imag = '0;
   logic                          csr_valid = 1'b0;
   logic [COUNT_WIDTH-1:0]        csr_max_iterations = '0;
   logic                          busy;
   logic                          rsp_strobe;
   logic [COUNT_WIDTH-1:0]        rsp_escape_count;
   logic                          csr_ready;
   int                            errors;
   int                            pending;
   int                            idle_pct = 0;
   int                            stall_cycles = 0;

   always #5 clock = ~clock;

   mandelbrot_escape_time_core DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_c_real         (req_c_real),
      .req_c_imag         (req_c_imag),
      .rsp_strobe         (rsp_strobe),
      .rsp_escape_count   (rsp_escape_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_max_iterations (csr_max_iterations)
   );

   escape_time_checker count_check (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_c_real         (req_c_real),
      .req_c_imag         (req_c_imag),
      .rsp_strobe         (rsp_strobe),
      .rsp_escape_count   (rsp_escape_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_max_iterations (csr_max_iterations),
      .errors             (errors),
      .pending            (pending)
   );

   // Start stays high between back-to-back points and drops only for a gap.
   task automatic send_point(input logic signed [COORD_WIDTH-1:0] re,
                             input logic signed [COORD_WIDTH-1:0] im);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start      <= 1'b1;
      req_c_real <= re;
      req_c_imag <= im;
      do @(posedge clock); while (busy);
   endtask

   // Most points lie around the set, where escape takes many iterations.
   task automatic send_random_point();
      logic signed [COORD_WIDTH-1:0] re;
      logic signed [COORD_WIDTH-1:0] im;
      if ($urandom_range(9) < 7) begin
         re = COORD_WIDTH'($urandom_range(12288) - 9216);
         im = COORD_WIDTH'($urandom_range(12288) - 6144);
      end else begin
         re = COORD_WIDTH'($urandom);
         im = COORD_WIDTH'($urandom);
      end
      send_point(re, im);
   endtask

   // The extra edge lets the checker count the point of the last transfer.
   task automatic wait_for_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_limit(input logic [COUNT_WIDTH-1:0] value);
      csr_valid          <= 1'b1;
      csr_max_iterations <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset limit of 256: field extremes, the origin, and points whose norm
      // lands exactly on four, either staying there or escaping afterward.
      send_point(16'sd0, 16'sd0);
      send_point(-16'sd32768, -16'sd32768);
      send_point(16'sd32767, 16'sd32767);
      send_point(-16'sd32768, 16'sd32767);
      send_point(16'sd32767, -16'sd32768);
      send_point(-16'sd8192, 16'sd0);
      send_point(16'sd8192, 16'sd0);
      send_point(16'sd0, 16'sd8192);
      send_point(16'sd0, -16'sd8192);
      send_point(16'sd1024, 16'sd0);
      send_point(-16'sd4096, 16'sd0);
      send_point(16'sd0, 16'sd4096);
      send_point(-16'sd3072, 16'sd410);
      send_point(-16'sd1, 16'sd1);
      wait_for_results();

      // A zero limit runs no iteration at all.
      write_limit(16'd0);
      send_point(16'sd0, 16'sd0);
      send_point(16'sd32767, -16'sd32768);
      send_point(-16'sd8192, 16'sd0);
      wait_for_results();

      idle_pct = 50;
      write_limit(16'd1);
      repeat (60) send_random_point();
      wait_for_results();

      // The largest limit: one point never escapes, so keep this phase short.
      idle_pct = 35;
      write_limit(16'hFFFF);
      send_point(16'sd0, 16'sd0);
      send_point(-16'sd3072, 16'sd410);
      send_point(16'sd8192, 16'sd0);
      repeat (3) send_point(COORD_WIDTH'($urandom), COORD_WIDTH'($urandom));
      wait_for_results();

      idle_pct = 0;
      write_limit(MAX_ITER_RESET);
      repeat (150) send_random_point();
      wait_for_results();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 3)
            0: idle_pct = 50;
            1: idle_pct = 35;
            default: idle_pct = 0;
         endcase
         if (phase == 3) begin
            write_limit(COUNT_WIDTH'($urandom_range(400, 100)));
         end else begin
            write_limit(COUNT_WIDTH'($urandom_range(64, 2)));
         end
         repeat (PHASE_POINTS) send_random_point();
         wait_for_results();
      end

      repeat (20) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/met_pkg.sv
hdl/met_front.sv
hdl/met_queue.sv
hdl/met_back.sv
hdl/mandelbrot_escape_time_core.sv
tb/escape_time_checker.sv
tb/tb.sv
